// File: hdl/assert_macros.svh
// Assertion macros for the gradient lookup block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define LGCL_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("lgcl check failed: condition must never hold");

// trig at one edge implies expr at the next edge, reset included
`define LGCL_NEXT(name, clk, trig, expr) \
  name: assert property (@(posedge clk) (trig) |=> (expr)) \
    else $error("lgcl check failed: expected condition one cycle later");

`endif

// File: hdl/lgcl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the linear gradient color lookup block.
// No dependencies.
package lgcl_pkg;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // spread modes
  localparam logic [1:0] SPREAD_PAD     = 2'd0;
  localparam logic [1:0] SPREAD_REFLECT = 2'd1;
  localparam logic [1:0] SPREAD_REPEAT  = 2'd2;
  localparam logic [1:0] SPREAD_ZERO    = 2'd3;

  // register indexes on the config port
  localparam logic [2:0] REG_SPREAD   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
  localparam logic [2:0] REG_STEP_X   = 3'd3;
  localparam logic [2:0] REG_STEP_Y   = 3'd4;

  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 16;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
  localparam int BACK_STAGES = 10;
  localparam int INFL_W      = $clog2(BACK_STAGES + 1);

  // position reduction widths: offset position, low chunk, folded value, reciprocal
  localparam int POS_W  = 34;
  localparam int LOW_W  = 20;
  localparam int FOLD_W = 28;
  localparam int RCP_W  = 27;

  typedef struct packed {
    logic [1:0]         spread_mode;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
  } cfg_t;

  typedef struct packed {
    logic [9:0]  entry_index;
    logic [31:0] entry_color;
  } load_t;

  // classified word between front and back
  typedef struct packed {
    logic               is_pixel;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    load_t              ld;
  } item_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef struct packed {
    logic              res_valid;
    logic [INFL_W-1:0] inflight;
  } back_stat_t;

endpackage

// File: hdl/lgcl_fifo.sv
`timescale 1ns / 1ps
// Small register FIFO used between front and back and on the result side.
// Depends on nothing.
module lgcl_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= din;
    end
  end

endmodule

// File: hdl/lgcl_front.sv
`timescale 1ns / 1ps
// Front end: accepts input words, drops out-of-range loads, forms pixel offsets.
// Depends on lgcl_pkg.
module lgcl_front #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  lgcl_pkg::cfg_t      cfg,
  input  logic                push,
  output logic                full,
  input  logic                cmd,
  input  logic signed [15:0]  pixel_x,
  input  logic signed [15:0]  pixel_y,
  input  logic [9:0]          entry_index,
  input  logic [31:0]         entry_color,
  input  logic                q_full,
  output logic                q_push,
  output lgcl_pkg::item_t     q_item
);

  logic            fv;
  logic            adv;
  logic            keep;
  lgcl_pkg::item_t item_next;

  assign adv    = !fv || !q_full;
  assign full   = !adv;
  assign q_push = fv && !q_full;

  // a load past the end of the table has no effect at all
  assign keep = (cmd == lgcl_pkg::CMD_PIXEL) || (32'(entry_index) < 32'(TABLE_SIZE));

  always_comb begin
    item_next.is_pixel       = (cmd == lgcl_pkg::CMD_PIXEL);
    item_next.dx             = 33'($signed({pixel_x, 16'h0000})) - 33'(cfg.origin_x);
    item_next.dy             = 33'($signed({pixel_y, 16'h0000})) - 33'(cfg.origin_y);
    item_next.ld.entry_index = entry_index;
    item_next.ld.entry_color = entry_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (adv) begin
      fv <= push && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && push) begin
      q_item <= item_next;
    end
  end

endmodule

// File: hdl/lgcl_back.sv
`timescale 1ns / 1ps
// Back end: position pipeline, spread folding and the color table memory.
// Depends on lgcl_pkg.
module lgcl_back #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lgcl_pkg::cfg_t       cfg,
  input  logic                 issue,
  input  lgcl_pkg::item_t      item,
  output lgcl_pkg::back_stat_t stat,
  output lgcl_pkg::rgba_t      color
);

  localparam int IW  = $clog2(TABLE_SIZE);
  localparam int DM  = 2 * TABLE_SIZE;            // reflect period
  localparam int DW  = $clog2(DM);
  localparam int PW  = lgcl_pkg::POS_W;
  localparam int LW  = lgcl_pkg::LOW_W;
  localparam int FW  = lgcl_pkg::FOLD_W;
  localparam int RW  = lgcl_pkg::RCP_W;
  localparam longint OFFSET    = longint'(DM) * ((64'h1_0000_0000 + longint'(DM) - 1) / DM);
  localparam int     CHUNK_MOD = (1 << LW) % DM;
  localparam longint RECIP     = (64'd1 << FW) / DM;
  localparam logic signed [PW-1:0] P_MAX = PW'(TABLE_SIZE - 1);
  localparam int NS = lgcl_pkg::BACK_STAGES;

  logic [NS:1]        sv;
  logic [NS:1]        spx;
  lgcl_pkg::load_t    ld [1:NS-1];

  logic signed [64:0] a1, b1;
  logic signed [65:0] s2;
  logic signed [PW-1:0] p3;
  logic [PW-1:0]      v4;
  logic [FW-1:0]      w5, w6;
  logic [RW-1:0]      q6;
  logic [FW+RW-1:0]   prod;
  logic [FW-1:0]      diff;
  logic [DW:0]        r7;
  logic [DW-1:0]      r8;
  logic [IW-1:0]      pad4, pad5, pad6, pad7, pad8;
  logic [IW-1:0]      idx9;
  logic [IW-1:0]      idx_next;
  logic [IW-1:0]      addr9;
  logic               adj;
  logic [31:0]        mem [TABLE_SIZE];
  logic [31:0]        rd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv  <= '0;
      spx <= '0;
    end else begin
      sv  <= {sv[NS-1:1], issue};
      spx <= {spx[NS-1:1], issue && item.is_pixel};
    end
  end

  always_ff @(posedge clk) begin
    ld[1] <= item.ld;
    for (int k = 2; k < NS; k++) begin
      ld[k] <= ld[k-1];
    end
  end

  // exact Q32.32 position, then integer part toward zero
  assign adj  = s2[65] && (s2[31:0] != '0);
  assign prod = (FW+RW)'(w5) * (FW+RW)'(RECIP);
  assign diff = w6 - FW'(q6) * FW'(DM);

  always_ff @(posedge clk) begin
    a1 <= 65'(item.dx) * 65'(cfg.step_x);
    b1 <= 65'(item.dy) * 65'(cfg.step_y);
    s2 <= 66'(a1) + 66'(b1);
    p3 <= $signed(s2[65:32] + {33'd0, adj});
    // offset by a multiple of the period so the floor modulo sees a positive value
    v4 <= $unsigned(p3) + PW'(OFFSET);
    if (p3 < 0) begin
      pad4 <= '0;
    end else if (p3 > P_MAX) begin
      pad4 <= IW'(TABLE_SIZE - 1);
    end else begin
      pad4 <= p3[IW-1:0];
    end
    // fold the high chunk: 2^LW is congruent to CHUNK_MOD
    w5   <= FW'(v4[PW-1:LW]) * FW'(CHUNK_MOD) + FW'(v4[LW-1:0]);
    pad5 <= pad4;
    // quotient estimate, low by at most one
    q6   <= prod[FW+RW-1:FW];
    w6   <= w5;
    pad6 <= pad5;
    r7   <= diff[DW:0];
    pad7 <= pad6;
    r8   <= (r7 >= (DW+1)'(DM)) ? DW'(r7 - (DW+1)'(DM)) : r7[DW-1:0];
    pad8 <= pad7;
    idx9 <= idx_next;
  end

  always_comb begin
    case (cfg.spread_mode)
      lgcl_pkg::SPREAD_PAD: begin
        idx_next = pad8;
      end
      lgcl_pkg::SPREAD_REFLECT: begin
        idx_next = (r8 > DW'(TABLE_SIZE - 1)) ? IW'(DW'(DM - 1) - r8) : IW'(r8);
      end
      lgcl_pkg::SPREAD_REPEAT: begin
        idx_next = (r8 >= DW'(TABLE_SIZE)) ? IW'(r8 - DW'(TABLE_SIZE)) : IW'(r8);
      end
      default: begin
        idx_next = '0;
      end
    endcase
  end

  // single port: loads write and pixels read in stream order
  assign addr9 = spx[NS-1] ? idx9 : IW'(ld[NS-1].entry_index);

  always_ff @(posedge clk) begin
    if (sv[NS-1] && !spx[NS-1]) begin
      mem[addr9] <= ld[NS-1].entry_color;
    end
    if (spx[NS-1]) begin
      rd10 <= mem[addr9];
    end
  end

  assign color          = lgcl_pkg::rgba_t'(rd10);
  assign stat.res_valid = spx[NS];
  assign stat.inflight  = lgcl_pkg::INFL_W'($countones(spx));

endmodule

// File: hdl/linear_gradient_color_lookup_core.sv
`timescale 1ns / 1ps
// Linear gradient color lookup: input word -> table color at gradient position.
// Depends on lgcl_pkg, lgcl_fifo, lgcl_front, lgcl_back and assert_macros.svh.
//
// Input channel (push/full): cmd 0 writes entry_color into table entry
// entry_index (ignored beyond the table); cmd 1 places pixel (pixel_x, pixel_y)
// on the gradient and yields one result word. Loads yield nothing.
// Result channel (empty/pop): red/green/blue/alpha of the oldest result.
// Config: APB registers spread_mode, origin_x, origin_y, step_x, step_y at
// byte addresses 0,4,8,12,16; write them only while the block is idle.
// Throughput: one word per clock in both directions while neither side stalls.
// From the accepting edge to empty going low a word passes one front register,
// the middle queue, a ten-stage position/fold pipeline ending in the
// single-port table read, and the result queue. Reset clears the config and
// valid registers and both queues; table contents stay undefined until loaded.
// When the receiver stalls, up to 16 results wait in the result queue; pixel
// issue holds once queued plus in-flight results would exceed that, the middle
// queue fills and full rises. Loads need no result slot.
module linear_gradient_color_lookup_core #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic signed [15:0] pixel_x,
  input  logic signed [15:0] pixel_y,
  input  logic [9:0]         entry_index,
  input  logic [31:0]        entry_color,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha
);

`include "assert_macros.svh"

  localparam int CW = lgcl_pkg::OUT_CNT_W;
  localparam int MW = $bits(lgcl_pkg::item_t);

  lgcl_pkg::cfg_t       cfg;
  lgcl_pkg::item_t      front_item;
  lgcl_pkg::item_t      head;
  lgcl_pkg::back_stat_t stat;
  lgcl_pkg::rgba_t      back_color;
  lgcl_pkg::rgba_t      out_word;
  logic                 front_push;
  logic                 mid_full;
  logic                 mid_empty;
  logic [$clog2(lgcl_pkg::MID_DEPTH+1)-1:0] mid_count;
  logic [MW-1:0]        head_bits;
  logic                 issue;
  logic                 out_full;
  logic [CW-1:0]        out_count;
  logic [CW:0]          credit_sum;
  logic [2:0]           reg_idx;
  logic                 wr_en;

  // ---------------- config registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        lgcl_pkg::REG_SPREAD:   cfg.spread_mode <= pwdata[1:0];
        lgcl_pkg::REG_ORIGIN_X: cfg.origin_x    <= $signed(pwdata);
        lgcl_pkg::REG_ORIGIN_Y: cfg.origin_y    <= $signed(pwdata);
        lgcl_pkg::REG_STEP_X:   cfg.step_x      <= $signed(pwdata);
        lgcl_pkg::REG_STEP_Y:   cfg.step_y      <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lgcl_pkg::REG_SPREAD:   prdata = {30'd0, cfg.spread_mode};
      lgcl_pkg::REG_ORIGIN_X: prdata = cfg.origin_x;
      lgcl_pkg::REG_ORIGIN_Y: prdata = cfg.origin_y;
      lgcl_pkg::REG_STEP_X:   prdata = cfg.step_x;
      lgcl_pkg::REG_STEP_Y:   prdata = cfg.step_y;
      default:                prdata = '0;
    endcase
  end

  // ---------------- front, middle queue, back
  lgcl_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .entry_index (entry_index),
    .entry_color (entry_color),
    .q_full      (mid_full),
    .q_push      (front_push),
    .q_item      (front_item)
  );

  lgcl_fifo #(.WIDTH(MW), .DEPTH(lgcl_pkg::MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .din   (front_item),
    .pop   (issue),
    .dout  (head_bits),
    .full  (mid_full),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign head = lgcl_pkg::item_t'(head_bits);

  // pixels issue only with a result slot reserved for them
  assign credit_sum = (CW+1)'(stat.inflight) + (CW+1)'(out_count);
  assign issue = !mid_empty &&
                 (!head.is_pixel || (credit_sum < (CW+1)'(lgcl_pkg::OUT_DEPTH)));

  lgcl_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .issue (issue),
    .item  (head),
    .stat  (stat),
    .color (back_color)
  );

  lgcl_fifo #(.WIDTH(32), .DEPTH(lgcl_pkg::OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (stat.res_valid),
    .din   (back_color),
    .pop   (pop),
    .dout  (out_word),
    .full  (out_full),
    .empty (empty),
    .count (out_count)
  );

  assign red   = out_word.red;
  assign green = out_word.green;
  assign blue  = out_word.blue;
  assign alpha = out_word.alpha;

  // ---------------- checks
  `LGCL_NEVER(a_out_overflow, clk, rst, stat.res_valid && out_full)
  `LGCL_NEVER(a_credit_bound, clk, rst, credit_sum > (CW+1)'(lgcl_pkg::OUT_DEPTH))
  `LGCL_NEVER(a_mid_count, clk, rst, mid_full && (mid_count == '0))
  `LGCL_NEXT(a_reset_empty, clk, rst, empty && !stat.res_valid)

endmodule
